// File: rtl/cdd_pkg.sv
`timescale 1ns / 1ps
package cdd_pkg;

   // Window store geometry: three planes of MAX_Y lines of MAX_X words
   localparam int MAX_X      = 64;
   localparam int MAX_Y      = 64;
   localparam int POS_W      = 6;
   localparam int ADDR_W     = 14;
   localparam int MEM_DEPTH  = 3 * MAX_X * MAX_Y;
   localparam int SAMPLE_W   = 32;

   // Stencil taps and tensor components
   localparam int NUM_TAPS   = 19;
   localparam int TAP_W      = 5;
   localparam int NUM_OPS    = 9;
   localparam int OP_W       = 4;
   localparam int STEP_W     = 3;
   localparam logic [TAP_W-1:0]  LAST_TAP  = 5'd19;
   localparam logic [OP_W-1:0]   LAST_OP   = 4'd8;
   localparam logic [STEP_W-1:0] LAST_STEP = 3'd7;

   // Register indexes
   localparam logic [2:0] CSR_GRID_X = 3'd0;
   localparam logic [2:0] CSR_GRID_Y = 3'd1;
   localparam logic [2:0] CSR_GRID_Z = 3'd2;
   localparam logic [2:0] CSR_GHOST  = 3'd3;
   localparam logic [2:0] CSR_INV_X  = 3'd4;
   localparam logic [2:0] CSR_INV_Y  = 3'd5;
   localparam logic [2:0] CSR_INV_Z  = 3'd6;

   // Component codes
   localparam logic [OP_W-1:0] OP_DX  = 4'd0;
   localparam logic [OP_W-1:0] OP_DY  = 4'd1;
   localparam logic [OP_W-1:0] OP_DZ  = 4'd2;
   localparam logic [OP_W-1:0] OP_DXX = 4'd3;
   localparam logic [OP_W-1:0] OP_DYY = 4'd4;
   localparam logic [OP_W-1:0] OP_DZZ = 4'd5;
   localparam logic [OP_W-1:0] OP_DXY = 4'd6;
   localparam logic [OP_W-1:0] OP_DXZ = 4'd7;
   localparam logic [OP_W-1:0] OP_DYZ = 4'd8;

   // Offset codes per axis
   localparam logic [1:0] OFS_M = 2'd0;
   localparam logic [1:0] OFS_C = 2'd1;
   localparam logic [1:0] OFS_P = 2'd2;

   typedef struct packed {
      logic              accept;
      logic              rd_en;
      logic [TAP_W-1:0]  rd_idx;
      logic              cap_en;
      logic [TAP_W-1:0]  cap_idx;
      logic              calc_en;
      logic [OP_W-1:0]   op;
      logic [STEP_W-1:0] step;
      logic              load_out;
   } cmd_type;

   typedef struct packed {
      logic interior;
   } sts_type;

   // Tap offsets {dz, dy, dx} around the center point
   function automatic logic [5:0] tap_offset(input logic [TAP_W-1:0] idx);
      logic [5:0] r;
      case (idx)
         5'd0:    r = {OFS_C, OFS_C, OFS_C};
         5'd1:    r = {OFS_C, OFS_C, OFS_P};
         5'd2:    r = {OFS_C, OFS_C, OFS_M};
         5'd3:    r = {OFS_C, OFS_P, OFS_C};
         5'd4:    r = {OFS_C, OFS_M, OFS_C};
         5'd5:    r = {OFS_P, OFS_C, OFS_C};
         5'd6:    r = {OFS_M, OFS_C, OFS_C};
         5'd7:    r = {OFS_C, OFS_P, OFS_P};
         5'd8:    r = {OFS_C, OFS_M, OFS_P};
         5'd9:    r = {OFS_C, OFS_P, OFS_M};
         5'd10:   r = {OFS_C, OFS_M, OFS_M};
         5'd11:   r = {OFS_P, OFS_C, OFS_P};
         5'd12:   r = {OFS_M, OFS_C, OFS_P};
         5'd13:   r = {OFS_P, OFS_C, OFS_M};
         5'd14:   r = {OFS_M, OFS_C, OFS_M};
         5'd15:   r = {OFS_P, OFS_P, OFS_C};
         5'd16:   r = {OFS_M, OFS_P, OFS_C};
         5'd17:   r = {OFS_P, OFS_M, OFS_C};
         5'd18:   r = {OFS_M, OFS_M, OFS_C};
         default: r = {OFS_C, OFS_C, OFS_C};
      endcase
      return r;
   endfunction

   // Plane slot for a z offset, given the slot of the newest plane
   function automatic logic [1:0] plane_sel(input logic [1:0] zm3, input logic [1:0] dz);
      logic [1:0] r;
      case ({dz, zm3})
         {OFS_P, 2'd0}: r = 2'd0;
         {OFS_P, 2'd1}: r = 2'd1;
         {OFS_P, 2'd2}: r = 2'd2;
         {OFS_C, 2'd0}: r = 2'd2;
         {OFS_C, 2'd1}: r = 2'd0;
         {OFS_C, 2'd2}: r = 2'd1;
         {OFS_M, 2'd0}: r = 2'd1;
         {OFS_M, 2'd1}: r = 2'd2;
         {OFS_M, 2'd2}: r = 2'd0;
         default:       r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/cdd_ctrl.sv
`timescale 1ns / 1ps
module cdd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  cdd_pkg::sts_type sts,
   output cdd_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_CALC = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [cdd_pkg::TAP_W-1:0]   cnt_ff, cnt_in;
   logic [cdd_pkg::OP_W-1:0]    op_ff, op_in;
   logic [cdd_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        valid_ff, valid_in;
   logic                        out_free;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

   // Sequence: take request, read taps, run components, hand off result
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.op   = op_ff;
      cmd.step = step_ff;
      cmd.rd_idx  = cnt_ff;
      cmd.cap_idx = cnt_ff - 5'd1;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (sts.interior) begin
                  state_in = ST_READ;
                  cnt_in   = '0;
               end
            end
         end
         ST_READ: begin
            cmd.rd_en  = (cnt_ff != cdd_pkg::LAST_TAP);
            cmd.cap_en = (cnt_ff != '0);
            if (cnt_ff == cdd_pkg::LAST_TAP) begin
               state_in = ST_CALC;
               op_in    = '0;
               step_in  = '0;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_CALC: begin
            cmd.calc_en = 1'b1;
            step_in     = step_ff + 3'd1;
            if (step_ff == cdd_pkg::LAST_STEP) begin
               if (op_ff == cdd_pkg::LAST_OP) begin
                  state_in = ST_DONE;
               end else begin
                  op_in = op_ff + 4'd1;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result valid until taken
   always_comb begin
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         op_ff    <= '0;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         op_ff    <= op_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

`ifndef SYNTHESIS
   a_interior_reads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_tvalid && sts.interior) |=> (state_ff == ST_READ))
      else $error("interior request did not start tap reads");
   a_calc_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC && step_ff == cdd_pkg::LAST_STEP && op_ff == cdd_pkg::LAST_OP)
      |=> (state_ff == ST_DONE))
      else $error("last component did not finish the point");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!valid_ff || rsp_tready))
      else $error("result overwritten before taken");
   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (cnt_ff <= cdd_pkg::LAST_TAP))
      else $error("tap counter out of range");
`endif

endmodule

// File: rtl/cdd_dpath.sv
`timescale 1ns / 1ps
module cdd_dpath (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      req_tdata,
   output logic [287:0]     rsp_tdata,
   output logic             rsp_tlast,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   input  cdd_pkg::cmd_type cmd,
   output cdd_pkg::sts_type sts
);

   // Configuration
   logic [6:0]  gsx_ff, gsy_ff, ghost_unused_w;
   logic [15:0] gsz_ff;
   logic [1:0]  ghost_ff;
   logic [31:0] invx_ff, invy_ff, invz_ff;

   // Raster position of the next sample
   logic [cdd_pkg::POS_W-1:0] pos_x_ff, pos_y_ff, ctr_x_ff, ctr_y_ff;
   logic [15:0]               pos_z_ff;
   logic [1:0]                zm3_ff, ctr_z_ff;
   logic                      last_ff;

   // Derived sizes
   logic [6:0]  nx, ny, x7, y7, g7;
   logic [16:0] nz, z17, g17;
   logic [1:0]  g;
   logic        interior, last_pt;

   // Memory and taps
   logic [cdd_pkg::SAMPLE_W-1:0] mem [0:cdd_pkg::MEM_DEPTH-1];
   logic [cdd_pkg::ADDR_W-1:0]   wr_addr, rd_addr;
   logic [31:0]                  rd_data_ff;
   logic signed [31:0]           samp_ff [0:cdd_pkg::NUM_TAPS-1];
   logic [5:0]                   ofs;

   // Arithmetic
   logic signed [34:0] num, num_ff;
   logic [34:0]        mag_ff;
   logic               neg_ff;
   logic [63:0]        m_ff, prod_ff;
   logic [31:0]        mul_a, mul_b, inv_a, inv_b;
   logic [99:0]        acc_ff;
   logic signed [100:0] sv, sh;
   logic [31:0]        sat;
   logic [31:0]        res_ff [0:cdd_pkg::NUM_OPS-1];
   logic [287:0]       rsp_data_ff;
   logic               rsp_last_ff;

   assign ghost_unused_w = 7'd0;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gsx_ff   <= 7'd64;
         gsy_ff   <= 7'd64;
         gsz_ff   <= 16'd64;
         ghost_ff <= 2'd1;
         invx_ff  <= 32'h0001_0000;
         invy_ff  <= 32'h0001_0000;
         invz_ff  <= 32'h0001_0000;
      end else if (csr_we) begin
         case (csr_index)
            cdd_pkg::CSR_GRID_X: gsx_ff   <= csr_wdata[6:0];
            cdd_pkg::CSR_GRID_Y: gsy_ff   <= csr_wdata[6:0];
            cdd_pkg::CSR_GRID_Z: gsz_ff   <= csr_wdata[15:0];
            cdd_pkg::CSR_GHOST:  ghost_ff <= csr_wdata[1:0];
            cdd_pkg::CSR_INV_X:  invx_ff  <= csr_wdata;
            cdd_pkg::CSR_INV_Y:  invy_ff  <= csr_wdata;
            cdd_pkg::CSR_INV_Z:  invz_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp sizes and ghost width
   always_comb begin
      if (gsx_ff < 7'd3) nx = 7'd3;
      else if (gsx_ff > 7'd64) nx = 7'd64;
      else nx = gsx_ff;
      if (gsy_ff < 7'd3) ny = 7'd3;
      else if (gsy_ff > 7'd64) ny = 7'd64;
      else ny = gsy_ff;
      nz  = (gsz_ff < 16'd3) ? 17'd3 : {1'b0, gsz_ff};
      g   = (ghost_ff == 2'd0) ? 2'd1 : ghost_ff;
      x7  = {1'b0, pos_x_ff};
      y7  = {1'b0, pos_y_ff};
      z17 = {1'b0, pos_z_ff};
      g7  = {5'd0, g} | ghost_unused_w;
      g17 = {15'd0, g};
      interior = (x7 >= g7 + 7'd1) && (x7 + g7 <= nx)
              && (y7 >= g7 + 7'd1) && (y7 + g7 <= ny)
              && (z17 >= g17 + 17'd1) && (z17 + g17 <= nz);
      last_pt  = (x7 + g7 == nx) && (y7 + g7 == ny) && (z17 + g17 == nz);
   end

   assign sts.interior = interior;

   // Advance the raster position on each request
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
         zm3_ff   <= '0;
      end else if (cmd.accept) begin
         if (x7 + 7'd1 >= nx) begin
            pos_x_ff <= '0;
            if (y7 + 7'd1 >= ny) begin
               pos_y_ff <= '0;
               if (z17 + 17'd1 >= nz) begin
                  pos_z_ff <= '0;
                  zm3_ff   <= '0;
               end else begin
                  pos_z_ff <= pos_z_ff + 16'd1;
                  zm3_ff   <= (zm3_ff == 2'd2) ? 2'd0 : zm3_ff + 2'd1;
               end
            end else begin
               pos_y_ff <= pos_y_ff + 6'd1;
            end
         end else begin
            pos_x_ff <= pos_x_ff + 6'd1;
         end
      end
   end

   // Latch the corner position that closes the stencil
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ctr_x_ff <= pos_x_ff;
         ctr_y_ff <= pos_y_ff;
         ctr_z_ff <= zm3_ff;
         last_ff  <= last_pt;
      end
   end

   // Window store addresses
   assign wr_addr = {zm3_ff, pos_y_ff, pos_x_ff};
   assign ofs     = cdd_pkg::tap_offset(cmd.rd_idx);
   assign rd_addr = {cdd_pkg::plane_sel(ctr_z_ff, ofs[5:4]),
                     ctr_y_ff - 6'd2 + {4'd0, ofs[3:2]},
                     ctr_x_ff - 6'd2 + {4'd0, ofs[1:0]}};

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mem[wr_addr] <= req_tdata;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Collect taps
   always_ff @(posedge clock) begin
      if (cmd.cap_en) begin
         samp_ff[cmd.cap_idx] <= rd_data_ff;
      end
   end

   // Numerator and spacing factors of the current component
   always_comb begin
      num   = '0;
      inv_a = invx_ff;
      inv_b = 32'd1;
      case (cmd.op)
         cdd_pkg::OP_DX: begin
            num = 35'(samp_ff[1]) - 35'(samp_ff[2]);
            inv_a = invx_ff;
         end
         cdd_pkg::OP_DY: begin
            num = 35'(samp_ff[3]) - 35'(samp_ff[4]);
            inv_a = invy_ff;
         end
         cdd_pkg::OP_DZ: begin
            num = 35'(samp_ff[5]) - 35'(samp_ff[6]);
            inv_a = invz_ff;
         end
         cdd_pkg::OP_DXX: begin
            num = 35'(samp_ff[1]) - (35'(samp_ff[0]) <<< 1) + 35'(samp_ff[2]);
            inv_a = invx_ff;
            inv_b = invx_ff;
         end
         cdd_pkg::OP_DYY: begin
            num = 35'(samp_ff[3]) - (35'(samp_ff[0]) <<< 1) + 35'(samp_ff[4]);
            inv_a = invy_ff;
            inv_b = invy_ff;
         end
         cdd_pkg::OP_DZZ: begin
            num = 35'(samp_ff[5]) - (35'(samp_ff[0]) <<< 1) + 35'(samp_ff[6]);
            inv_a = invz_ff;
            inv_b = invz_ff;
         end
         cdd_pkg::OP_DXY: begin
            num = 35'(samp_ff[7]) - 35'(samp_ff[8]) - 35'(samp_ff[9]) + 35'(samp_ff[10]);
            inv_a = invx_ff;
            inv_b = invy_ff;
         end
         cdd_pkg::OP_DXZ: begin
            num = 35'(samp_ff[11]) - 35'(samp_ff[12]) - 35'(samp_ff[13])
                + 35'(samp_ff[14]);
            inv_a = invx_ff;
            inv_b = invz_ff;
         end
         cdd_pkg::OP_DYZ: begin
            num = 35'(samp_ff[15]) - 35'(samp_ff[16]) - 35'(samp_ff[17])
                + 35'(samp_ff[18]);
            inv_a = invy_ff;
            inv_b = invz_ff;
         end
         default: begin
            num = '0;
         end
      endcase
   end

   // Shared 32x32 multiplier operands per step
   always_comb begin
      case (cmd.step)
         3'd0:    begin mul_a = inv_a;                    mul_b = inv_b;        end
         3'd2:    begin mul_a = mag_ff[31:0];             mul_b = m_ff[31:0];   end
         3'd3:    begin mul_a = mag_ff[31:0];             mul_b = m_ff[63:32];  end
         3'd4:    begin mul_a = {29'd0, mag_ff[34:32]};   mul_b = m_ff[31:0];   end
         3'd5:    begin mul_a = {29'd0, mag_ff[34:32]};   mul_b = m_ff[63:32];  end
         default: begin mul_a = '0;                       mul_b = '0;           end
      endcase
   end

   // Apply sign, shift by the divisor and scale exponent, saturate
   always_comb begin
      sv = neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
      if (cmd.op <= cdd_pkg::OP_DZ) begin
         sh = sv >>> 17;
      end else if (cmd.op <= cdd_pkg::OP_DZZ) begin
         sh = sv >>> 32;
      end else begin
         sh = sv >>> 34;
      end
      if (sh[100:31] == '0 || sh[100:31] == '1) begin
         sat = sh[31:0];
      end else if (sh[100]) begin
         sat = 32'h8000_0000;
      end else begin
         sat = 32'h7fff_ffff;
      end
   end

   // Step through one component: factor, four partial products, finish
   always_ff @(posedge clock) begin
      if (cmd.calc_en) begin
         prod_ff <= 64'(mul_a) * 64'(mul_b);
         case (cmd.step)
            3'd0: begin
               num_ff <= num;
            end
            3'd1: begin
               m_ff   <= prod_ff;
               neg_ff <= num_ff[34];
               mag_ff <= num_ff[34] ? 35'(-num_ff) : 35'(num_ff);
               acc_ff <= '0;
            end
            3'd3: acc_ff <= acc_ff + 100'(prod_ff);
            3'd4: acc_ff <= acc_ff + (100'(prod_ff) << 32);
            3'd5: acc_ff <= acc_ff + (100'(prod_ff) << 32);
            3'd6: acc_ff <= acc_ff + (100'(prod_ff) << 64);
            3'd7: res_ff[cmd.op] <= sat;
            default: ;
         endcase
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= {res_ff[8], res_ff[7], res_ff[6], res_ff[5], res_ff[4],
                         res_ff[3], res_ff[2], res_ff[1], res_ff[0]};
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule

// File: rtl/central_difference_3d_derivatives_top.sv
`timescale 1ns / 1ps
// Second-order central-difference stencil over a raster-ordered 3-D grid.
// req_*: one signed Q16.16 sample per request, x fastest, then y, then z.
// rsp_*: one result per interior point; tdata carries deriv_x, deriv_y,
//   deriv_z, deriv_xx, deriv_yy, deriv_zz, deriv_xy, deriv_xz, deriv_yz,
//   32 bits each from bit 0 up; tlast marks the final interior point.
// csr_*: register writes (grid sizes, ghost width, inverse spacings); the user
//   must make them only while the block is idle, which the block does not enforce.
// A request whose stencil is not interior is stored and the block stays ready.
// An interior one is taken, then its 19 taps are read through the single
// window store read port, nine components of eight steps each run on the
// shared 32x32 multiplier, and the result is loaded into the output register.
// The output register holds a result while rsp_tready is low; the next
// request is still taken, and its result waits for the register to free.
// Reset clears position, control and registers to their defaults; the
// window store is not cleared and needs no clearing pass.
module central_difference_3d_derivatives_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // field_sample
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [287:0] rsp_tdata,   // deriv_x, deriv_y, deriv_z, deriv_xx, deriv_yy,
                                     // deriv_zz, deriv_xy, deriv_xz, deriv_yz
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   cdd_pkg::cmd_type cmd;
   cdd_pkg::sts_type sts;

   cdd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cdd_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// File: tb/sv/cdd_checker.sv
`timescale 1ns / 1ps
module cdd_checker
   import cdd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [31:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [287:0] rsp_tdata,
   input  logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata,
   output int           fail_count,
   output int           pending
);

   typedef struct packed {
      logic [287:0] derivs;
      logic         last;
   } deriv_set_t;

   localparam int PLANE = MAX_X * MAX_Y;
   localparam logic signed [127:0] SAT_HI = 128'sh7fffffff;
   localparam logic signed [127:0] SAT_LO = -128'sh80000000;

   logic [31:0] plane_store [0:3*PLANE-1];
   int unsigned px, py, pz;
   logic [6:0]  size_x, size_y;
   logic [15:0] size_z;
   logic [1:0]  ghost;
   logic [63:0] inv_x, inv_y, inv_z;
   deriv_set_t  deriv_q [$];
   string       comp_name [9] = '{"deriv_x", "deriv_y", "deriv_z", "deriv_xx", "deriv_yy",
                                  "deriv_zz", "deriv_xy", "deriv_xz", "deriv_yz"};

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic longint tap(int unsigned z, int unsigned y, int unsigned x);
      return longint'($signed(plane_store[(z % 3) * PLANE + (y % MAX_Y) * MAX_X + (x % MAX_X)]));
   endfunction

   // floor(n * m / 2^k), saturated to the signed 32-bit range
   function automatic logic [31:0] scale_sat(longint n, logic [63:0] m, int k);
      logic signed [127:0] a, b, q;
      a = n;
      b = {64'd0, m};
      q = (a * b) >>> k;
      if (q > SAT_HI) return 32'h7fffffff;
      if (q < SAT_LO) return 32'h80000000;
      return q[31:0];
   endfunction

   // Store the sample, predict the stencil result, and advance the raster position
   function automatic void take_sample(logic [31:0] d);
      int unsigned nx, ny, nz, g, cx, cy, cz;
      longint c, xp, xm, yp, ym, zp, zm, nxy, nxz, nyz;
      deriv_set_t e;
      nx = size_x < 3 ? 3 : (size_x > MAX_X ? MAX_X : size_x);
      ny = size_y < 3 ? 3 : (size_y > MAX_Y ? MAX_Y : size_y);
      nz = size_z < 3 ? 3 : size_z;
      g  = ghost == 0 ? 1 : ghost;
      plane_store[(pz % 3) * PLANE + (py % MAX_Y) * MAX_X + (px % MAX_X)] = d;
      if (px >= g + 1 && px + g <= nx && py >= g + 1 && py + g <= ny &&
          pz >= g + 1 && pz + g <= nz) begin
         cx = px - 1; cy = py - 1; cz = pz - 1;
         c  = tap(cz, cy, cx);
         xp = tap(cz, cy, cx + 1); xm = tap(cz, cy, cx - 1);
         yp = tap(cz, cy + 1, cx); ym = tap(cz, cy - 1, cx);
         zp = tap(cz + 1, cy, cx); zm = tap(cz - 1, cy, cx);
         nxy = tap(cz, cy + 1, cx + 1) - tap(cz, cy - 1, cx + 1)
             - tap(cz, cy + 1, cx - 1) + tap(cz, cy - 1, cx - 1);
         nxz = tap(cz + 1, cy, cx + 1) - tap(cz - 1, cy, cx + 1)
             - tap(cz + 1, cy, cx - 1) + tap(cz - 1, cy, cx - 1);
         nyz = tap(cz + 1, cy + 1, cx) - tap(cz - 1, cy + 1, cx)
             - tap(cz + 1, cy - 1, cx) + tap(cz - 1, cy - 1, cx);
         e.derivs[31:0]    = scale_sat(xp - xm, inv_x, 17);
         e.derivs[63:32]   = scale_sat(yp - ym, inv_y, 17);
         e.derivs[95:64]   = scale_sat(zp - zm, inv_z, 17);
         e.derivs[127:96]  = scale_sat(xp - 2 * c + xm, inv_x * inv_x, 32);
         e.derivs[159:128] = scale_sat(yp - 2 * c + ym, inv_y * inv_y, 32);
         e.derivs[191:160] = scale_sat(zp - 2 * c + zm, inv_z * inv_z, 32);
         e.derivs[223:192] = scale_sat(nxy, inv_x * inv_y, 34);
         e.derivs[255:224] = scale_sat(nxz, inv_x * inv_z, 34);
         e.derivs[287:256] = scale_sat(nyz, inv_y * inv_z, 34);
         e.last = (px + g == nx) && (py + g == ny) && (pz + g == nz);
         deriv_q.push_back(e);
      end
      if (px + 1 >= nx) begin
         px = 0;
         if (py + 1 >= ny) begin
            py = 0;
            pz = (pz + 1 >= nz) ? 0 : pz + 1;
         end else begin
            py = py + 1;
         end
      end else begin
         px = px + 1;
      end
   endfunction

   // Track registers, predict on each request, compare each result
   always @(posedge clock) begin
      deriv_set_t e;
      if (reset) begin
         px = 0; py = 0; pz = 0;
         size_x = 7'd64; size_y = 7'd64; size_z = 16'd64; ghost = 2'd1;
         inv_x = 64'd65536; inv_y = 64'd65536; inv_z = 64'd65536;
         deriv_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GRID_X: size_x = csr_wdata[6:0];
               CSR_GRID_Y: size_y = csr_wdata[6:0];
               CSR_GRID_Z: size_z = csr_wdata[15:0];
               CSR_GHOST:  ghost  = csr_wdata[1:0];
               CSR_INV_X:  inv_x  = {32'd0, csr_wdata};
               CSR_INV_Y:  inv_y  = {32'd0, csr_wdata};
               CSR_INV_Z:  inv_z  = {32'd0, csr_wdata};
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (deriv_q.size() == 0) begin
               $error("unexpected result: %h", rsp_tdata);
               fail_count++;
            end else begin
               e = deriv_q.pop_front();
               for (int i = 0; i < 9; i++) begin
                  if (rsp_tdata[32*i +: 32] !== e.derivs[32*i +: 32]) begin
                     $error("%s: expected %h, actual %h", comp_name[i],
                            e.derivs[32*i +: 32], rsp_tdata[32*i +: 32]);
                     fail_count++;
                  end
               end
               if (rsp_tlast !== e.last) begin
                  $error("last_point: expected %b, actual %b", e.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) take_sample(req_tdata);
      end
      pending = deriv_q.size();
   end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import cdd_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_WAIT  = 120;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid, req_tready;
   logic [31:0]  req_tdata;
   logic         rsp_tvalid, rsp_tready;
   logic [287:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [31:0]  csr_wdata;
   int           fail_count, pending;
   int           cycles = 0;
   bit           req_busy_run = 0;
   bit           rsp_busy_run = 0;
   int           results_taken = 0;
   int           sent = 0;

   central_difference_3d_derivatives_top dut (.*);

   cdd_checker chk (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result side: random stalls, one long hold-off to back the block up
   initial begin
      int w;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         w = rsp_busy_run ? 0 : $urandom_range(0, 10);
         if (w > 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         results_taken++;
         if (results_taken == 40) begin
            rsp_tready <= 1'b0;
            repeat (3000) @(posedge clock);
         end
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_request(logic [31:0] d);
      int gap;
      gap = req_busy_run ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // Wait for every expected result, then let a non-interior tail settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_inv();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return 32'hffffffff;
         2:       return 32'd65536;
         3, 4:    return $urandom_range(1, 32'h40000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_sample(int mode);
      case (mode)
         0: begin
            case ($urandom_range(0, 3))
               0:       return 32'h7fffffff;
               1:       return 32'h80000000;
               2:       return 32'h00000000;
               default: return 32'hffffffff;
            endcase
         end
         1:       return $urandom_range(0, 32'h1fffff) - 32'h100000;
         default: return $urandom;
      endcase
   endfunction

   // Program one grid setting and stream one complete grid through it
   task automatic run_grid(int sx, int sy, int sz, int gh,
                           logic [31:0] ix, logic [31:0] iy, logic [31:0] iz, int mode);
      int nx, ny, nz;
      csr_write(CSR_GRID_X, sx);
      csr_write(CSR_GRID_Y, sy);
      csr_write(CSR_GRID_Z, sz);
      csr_write(CSR_GHOST, gh);
      csr_write(CSR_INV_X, ix);
      csr_write(CSR_INV_Y, iy);
      csr_write(CSR_INV_Z, iz);
      nx = sx < 3 ? 3 : (sx > MAX_X ? MAX_X : sx);
      ny = sy < 3 ? 3 : (sy > MAX_Y ? MAX_Y : sy);
      nz = sz < 3 ? 3 : sz;
      for (int i = 0; i < nx * ny * nz; i++) send_request(pick_sample(mode));
      drain();
   endtask

   initial begin
      int sx, sy, sz, gh;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_GRID_X;
      csr_wdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: smallest grid with extreme samples and the widest spacings,
      // then zero spacing, oversized ghost, zero ghost and undersized sizes
      run_grid(3, 3, 3, 1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
      run_grid(3, 3, 3, 1, 32'd0, 32'd0, 32'd0, 2);
      run_grid(3, 3, 3, 2, 32'd65536, 32'd65536, 32'd65536, 2);
      run_grid(0, 1, 2, 0, 32'd1, 32'd65536, 32'hffffffff, 0);

      // Random grids until the item budget is spent
      while (sent < 1000) begin
         req_busy_run = ($urandom_range(0, 3) == 0);
         rsp_busy_run = ($urandom_range(0, 3) == 0);
         sx = $urandom_range(3, 8);
         sy = $urandom_range(3, 8);
         sz = $urandom_range(3, 6);
         case ($urandom_range(0, 19))
            0: sx = $urandom_range(0, 2);
            1: sy = $urandom_range(0, 2);
            2: sz = $urandom_range(0, 2);
            3: begin
               sx = $urandom_range(64, 127); sy = 3; sz = 3;
            end
            4: begin
               sy = $urandom_range(64, 127); sx = 3; sz = 3;
            end
            default: ;
         endcase
         case ($urandom_range(0, 9))
            0:       gh = 0;
            1, 2:    gh = 2;
            3:       gh = 3;
            default: gh = 1;
         endcase
         run_grid(sx, sy, sz, gh, pick_inv(), pick_inv(), pick_inv(), $urandom_range(0, 4));
      end
      req_busy_run = 0;
      rsp_busy_run = 0;
      drain();

      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
